/* design/mra_pkg.sv */
package mra_pkg;

  // default largest modulus; sets the inverse table size
  localparam int MAX_MODULUS_DEF = 16;

  // configuration data width and modulus after reset
  localparam int CFG_W         = 5;
  localparam int MODULUS_RESET = 5;

  // operand and result widths
  localparam int OPD_W = 4;
  localparam int RES_W = 4;
  localparam int CMD_W = 3;

  typedef logic [CMD_W-1:0] cmd_t;

  localparam cmd_t CMD_ADD = 3'd0;
  localparam cmd_t CMD_SUB = 3'd1;
  localparam cmd_t CMD_MUL = 3'd2;
  localparam cmd_t CMD_DIV = 3'd3;
  localparam cmd_t CMD_NEG = 3'd4;
  localparam cmd_t CMD_INV = 3'd5;
  localparam cmd_t CMD_INC = 3'd6;
  localparam cmd_t CMD_DEC = 3'd7;

  localparam logic STATUS_OK     = 1'b0;
  localparam logic STATUS_NO_INV = 1'b1;

endpackage

/* design/mra_if.sv */
interface mra_in_if;
  import mra_pkg::*;

  logic             valid;
  logic             ready;
  cmd_t             cmd;
  logic [OPD_W-1:0] operand_a;
  logic [OPD_W-1:0] operand_b;

  modport source (output valid, output cmd, output operand_a, output operand_b, input ready);
  modport sink   (input valid, input cmd, input operand_a, input operand_b, output ready);
endinterface

interface mra_out_if;
  import mra_pkg::*;

  logic             valid;
  logic             ready;
  logic [RES_W-1:0] result;
  logic             status;

  modport source (output valid, output result, output status, input ready);
  modport sink   (input valid, input result, input status, output ready);
endinterface

/* design/mra_ram.sv */
module mra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/mra_reduce.sv */
// value mod modulus by restoring subtraction of shifted moduli (modulus >= 2)
module mra_reduce #(
  parameter int VAL_W = 4,
  parameter int MOD_W = 5
) (
  input  logic [VAL_W-1:0] value,
  input  logic [MOD_W-1:0] modulus,
  output logic [VAL_W-1:0] remainder
);

  localparam int CW = VAL_W + MOD_W;

  logic [CW-1:0] r;
  logic [CW-1:0] d;

  always_comb begin
    r = CW'(value);
    d = '0;
    // quotient stays below 2**(VAL_W-1) since modulus is at least 2
    for (int s = VAL_W - 2; s >= 0; s--) begin
      d = CW'(modulus) << s;
      if (r >= d) begin
        r = r - d;
      end
    end
    remainder = r[VAL_W-1:0];
  end

endmodule

/* design/modular_ring_alu_top.sv */
// Modular ring ALU: add, sub, mul, div, neg, inverse, increment and decrement of
// 4-bit operands in the integers modulo a configured modulus (2..MAX_MODULUS,
// reset value 5; writes outside that range are ignored). Operands are reduced
// modulo the modulus first. Inverse and div give result 0 with status 1 when
// the operand (the second one for div) has no inverse, zero included. Inverses
// come from a table memory of (MAX_MODULUS+1)*MAX_MODULUS entries that is built
// after reset by a fill sequencer: it walks every modulus, value and candidate
// factor, one candidate per cycle, and req.ready stays low until the fill is
// done; configuration writes are taken at any time. After that the block
// accepts one item per cycle while rsp.ready does not hold the pipeline back;
// each item passes through operand reduction and table read, multiply or add,
// final reduction, output register. Each stage has its own enable, so items
// keep entering while a finished result waits for rsp.ready, until every
// stage is full. Write the modulus only while no item is in flight.
module modular_ring_alu_top #(
  parameter int MAX_MODULUS = mra_pkg::MAX_MODULUS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [mra_pkg::CFG_W-1:0] cfg_wdata,
  mra_in_if.sink                    req,
  mra_out_if.source                 rsp
);
  import mra_pkg::*;

  // table geometry
  localparam int DEPTH  = (MAX_MODULUS + 1) * MAX_MODULUS;
  localparam int AW     = $clog2(DEPTH);
  localparam int MOD_W  = $clog2(MAX_MODULUS + 1);
  localparam int X_W    = $clog2(MAX_MODULUS);
  localparam int SUM_W  = ((MOD_W > X_W) ? MOD_W : X_W) + 1;
  // datapath widths
  localparam int Y_W    = (X_W > OPD_W) ? X_W : OPD_W;
  localparam int PROD_W = OPD_W + Y_W;
  localparam int ADD_W  = ((OPD_W > MOD_W) ? OPD_W : MOD_W) + 1;
  localparam int RAW_W  = (PROD_W > ADD_W) ? PROD_W : ADD_W;

  localparam logic ST_FILL = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic [0:0]       state;
  logic [MOD_W-1:0] modulus;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= MOD_W'(MODULUS_RESET);
    end else if (cfg_we && (int'(cfg_wdata) >= 2) && (int'(cfg_wdata) <= MAX_MODULUS)) begin
      modulus <= MOD_W'(cfg_wdata);
    end
  end

  // ---------------- inverse table fill ----------------
  // per (modulus fm, value fx) walk candidates fk, fp tracks fk*fx mod fm
  logic [MOD_W-1:0] fm;
  logic [X_W-1:0]   fx;
  logic [X_W-1:0]   fk;
  logic [MOD_W-1:0] fp;
  logic [X_W-1:0]   finv;
  logic [X_W-1:0]   finv_now;
  logic [SUM_W-1:0] fsum;
  logic [SUM_W-1:0] fsum_red;
  logic             fhit;
  logic             flast_k;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic             ram_re;
  logic [AW-1:0]    ram_raddr;
  logic [X_W-1:0]   ram_rdata;

  assign fsum = SUM_W'(fp) + SUM_W'(fx);

  mra_reduce #(
    .VAL_W (SUM_W),
    .MOD_W (MOD_W)
  ) u_fill_reduce (
    .value     (fsum),
    .modulus   (fm),
    .remainder (fsum_red)
  );

  // smallest nonzero candidate wins, the entry is written together with the last one
  assign fhit     = (fk != '0) && (fp == MOD_W'(1)) && (finv == '0);
  assign finv_now = fhit ? fk : finv;
  assign flast_k  = (fk == X_W'(MAX_MODULUS - 1));

  assign ram_we    = (state == ST_FILL) && flast_k;
  assign ram_waddr = AW'(fm) * AW'(MAX_MODULUS) + AW'(fx);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
      fm    <= MOD_W'(2);
      fx    <= '0;
      fk    <= '0;
      fp    <= '0;
      finv  <= '0;
    end else if (state == ST_FILL) begin
      if (flast_k) begin
        fk   <= '0;
        fp   <= '0;
        finv <= '0;
        if (fx == X_W'(MAX_MODULUS - 1)) begin
          fx <= '0;
          if (fm == MOD_W'(MAX_MODULUS)) begin
            state <= ST_RUN;
          end else begin
            fm <= fm + MOD_W'(1);
          end
        end else begin
          fx <= fx + X_W'(1);
        end
      end else begin
        fk   <= fk + X_W'(1);
        fp   <= fsum_red[MOD_W-1:0];
        finv <= finv_now;
      end
    end
  end

  // ---------------- pipeline enables ----------------
  // each stage moves when it is empty or the next one moves
  logic v1, v2, v3, vo;
  logic en1, en2, en3, eno;

  assign eno = !vo || rsp.ready;
  assign en3 = !v3 || eno;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;

  assign req.ready = en1 && (state == ST_RUN);

  // ---------------- stage 1: reduce operands, read table ----------------
  cmd_t             cmd1;
  logic [OPD_W-1:0] a1, b1;
  logic [OPD_W-1:0] a1_red, b1_red;
  logic [OPD_W-1:0] inv_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req.valid && req.ready;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cmd1 <= req.cmd;
      a1   <= req.operand_a;
      b1   <= req.operand_b;
    end
  end

  mra_reduce #(
    .VAL_W (OPD_W),
    .MOD_W (MOD_W)
  ) u_reduce_a (
    .value     (a1),
    .modulus   (modulus),
    .remainder (a1_red)
  );

  mra_reduce #(
    .VAL_W (OPD_W),
    .MOD_W (MOD_W)
  ) u_reduce_b (
    .value     (b1),
    .modulus   (modulus),
    .remainder (b1_red)
  );

  // div looks up the second operand, everything else the first
  assign inv_idx   = (cmd1 == CMD_DIV) ? b1_red : a1_red;
  assign ram_re    = en2;
  assign ram_raddr = AW'(modulus) * AW'(MAX_MODULUS) + AW'(inv_idx);

  mra_ram #(
    .WIDTH (X_W),
    .DEPTH (DEPTH)
  ) u_inv_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (finv_now),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- stage 2: raw value ----------------
  cmd_t              cmd2;
  logic [OPD_W-1:0]  a2, b2;
  logic [Y_W-1:0]    mul_y;
  logic [PROD_W-1:0] prod;
  logic              no_inv;
  logic [RAW_W-1:0]  raw_next;
  logic              st_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      cmd2 <= cmd1;
      a2   <= a1_red;
      b2   <= b1_red;
    end
  end

  // a table entry of zero marks a value without inverse
  assign no_inv = (ram_rdata == '0);
  assign mul_y  = (cmd2 == CMD_DIV) ? Y_W'(ram_rdata) : Y_W'(b2);
  assign prod   = PROD_W'(a2) * PROD_W'(mul_y);

  always_comb begin
    raw_next = '0;
    st_next  = STATUS_OK;
    case (cmd2)
      CMD_ADD: raw_next = RAW_W'(a2) + RAW_W'(b2);
      CMD_SUB: raw_next = RAW_W'(a2) + RAW_W'(modulus) - RAW_W'(b2);
      CMD_MUL: raw_next = RAW_W'(prod);
      CMD_DIV: begin
        if (no_inv) begin
          st_next = STATUS_NO_INV;
        end else begin
          raw_next = RAW_W'(prod);
        end
      end
      CMD_NEG: raw_next = RAW_W'(modulus) - RAW_W'(a2);
      CMD_INV: begin
        if (no_inv) begin
          st_next = STATUS_NO_INV;
        end else begin
          raw_next = RAW_W'(ram_rdata);
        end
      end
      CMD_INC: raw_next = RAW_W'(a2) + RAW_W'(1);
      CMD_DEC: raw_next = RAW_W'(a2) + RAW_W'(modulus) - RAW_W'(1);
      default: raw_next = '0;
    endcase
  end

  // ---------------- stage 3: final reduction ----------------
  logic [RAW_W-1:0] raw3;
  logic             st3;
  logic [RAW_W-1:0] raw3_red;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      raw3 <= raw_next;
      st3  <= st_next;
    end
  end

  mra_reduce #(
    .VAL_W (RAW_W),
    .MOD_W (MOD_W)
  ) u_reduce_raw (
    .value     (raw3),
    .modulus   (modulus),
    .remainder (raw3_red)
  );

  // ---------------- output register ----------------
  logic [RES_W-1:0] result;
  logic             status;

  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else if (eno) begin
      vo <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (eno) begin
      result <= raw3_red[RES_W-1:0];
      status <= st3;
    end
  end

  assign rsp.valid  = vo;
  assign rsp.result = result;
  assign rsp.status = status;

`ifndef SYNTHESIS
  // a missing inverse always comes with a zero result
  a_noinv_zero: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == STATUS_NO_INV) |-> (rsp.result == '0))
    else $error("no-inverse status with nonzero result");

  // results only once the inverse table is complete
  a_out_after_fill: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> (state == ST_RUN))
    else $error("result while table fill is running");

  // results stay inside the ring
  a_res_range: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> ((MOD_W + 1)'(rsp.result) < (MOD_W + 1)'(modulus))
      || (int'(modulus) > (1 << RES_W)))
    else $error("result not below modulus");

  // fill ends only after the last entry of the largest modulus
  a_fill_end: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_RUN) |-> $past(ram_we && (fm == MOD_W'(MAX_MODULUS))
      && (fx == X_W'(MAX_MODULUS - 1))))
    else $error("table fill ended early");
`endif

endmodule

/* sim/modular_ring_alu_top_test.sv */
module modular_ring_alu_top_test;
  import mra_pkg::*;

  // cycles in which no item is accepted or delivered before the run is declared
  // hung; covers the inverse table fill after reset with margin
  localparam int HANG_LIMIT = 20000;
  // cycles to let the pipeline drain before a modulus write or the end
  localparam int DRAIN_CYCLES = 10;
  localparam int NUM_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 100;

  typedef struct {
    cmd_t             cmd;
    logic [OPD_W-1:0] a;
    logic [OPD_W-1:0] b;
  } ring_op_t;

  typedef struct {
    logic [RES_W-1:0] result;
    logic             status;
    ring_op_t         op;
  } ring_res_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [CFG_W-1:0]   cfg_wdata;

  mra_in_if  req_ch ();
  mra_out_if rsp_ch ();

  modular_ring_alu_top uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  // operations waiting to be sent, and results the block still owes us
  ring_op_t  op_q[$];
  ring_res_t owed_q[$];

  // our copy of the ring modulus, tracks every accepted write
  int unsigned ring_mod;
  int          mismatches;
  int          idle_cycles;
  bit          no_gaps;
  int          in_wait;
  int          out_wait;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // smallest k >= 1 below the table width with k*x == 1 mod m, 0 when none
  function automatic int unsigned ring_inverse(int unsigned m, int unsigned x);
    for (int unsigned k = 1; k < MAX_MODULUS_DEF; k++) begin
      if ((k * x) % m == 1) return k;
    end
    return 0;
  endfunction

  // expected result and status of one operation in the integers mod m
  function automatic ring_res_t ring_compute(ring_op_t op, int unsigned m);
    int unsigned a;
    int unsigned b;
    int unsigned inv;
    int unsigned res;
    ring_res_t   r;
    a = op.a % m;
    b = op.b % m;
    res = 0;
    r.status = STATUS_OK;
    r.op = op;
    case (op.cmd)
      CMD_ADD: res = (a + b) % m;
      CMD_SUB: res = (a + m - b) % m;
      CMD_MUL: res = (a * b) % m;
      CMD_DIV: begin
        inv = ring_inverse(m, b);
        if (inv == 0) r.status = STATUS_NO_INV;
        else res = (a * inv) % m;
      end
      CMD_NEG: res = (m - a) % m;
      CMD_INV: begin
        inv = ring_inverse(m, a);
        if (inv == 0) r.status = STATUS_NO_INV;
        else res = inv % m;
      end
      CMD_INC: res = (a + 1) % m;
      default: res = (a + m - 1) % m;
    endcase
    r.result = res[RES_W-1:0];
    return r;
  endfunction

  task automatic push_op(cmd_t cmd, int unsigned a, int unsigned b);
    ring_op_t op;
    op.cmd = cmd;
    op.a = a[OPD_W-1:0];
    op.b = b[OPD_W-1:0];
    op_q.push_back(op);
  endtask

  // wait until every operation is sent and answered, then let the pipe drain
  task automatic wait_drained();
    while (op_q.size() != 0 || req_ch.valid || owed_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one modulus write; out-of-range values must leave the modulus alone
  task automatic write_modulus(logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (v >= 2 && v <= MAX_MODULUS_DEF) ring_mod = 32'(v);
  endtask

  // request side: one operation at a time from op_q, random gap after each item unless no_gaps is set
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
      in_wait = 0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        owed_q.push_back(ring_compute('{req_ch.cmd, req_ch.operand_a, req_ch.operand_b},
                                      ring_mod));
        in_wait = no_gaps ? 0 : $urandom_range(0, 7);
      end
      // only move on when nothing is held waiting for ready
      if (!req_ch.valid || req_ch.ready) begin
        if (in_wait == 0 && op_q.size() != 0) begin
          req_ch.valid <= 1'b1;
          req_ch.cmd <= op_q[0].cmd;
          req_ch.operand_a <= op_q[0].a;
          req_ch.operand_b <= op_q[0].b;
          void'(op_q.pop_front());
        end else begin
          req_ch.valid <= 1'b0;
          if (in_wait > 0) in_wait--;
        end
      end
    end
  end

  // response side: check each item against the oldest owed result
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      out_wait = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual result %0d status %0d",
                   $time, rsp_ch.result, rsp_ch.status);
          mismatches++;
        end else begin
          if (rsp_ch.result !== owed_q[0].result || rsp_ch.status !== owed_q[0].status) begin
            $display("%0t: cmd %0d a %0d b %0d mod %0d: expected %0d/%0d, actual %0d/%0d",
                     $time, owed_q[0].op.cmd, owed_q[0].op.a, owed_q[0].op.b, ring_mod,
                     owed_q[0].result, owed_q[0].status, rsp_ch.result, rsp_ch.status);
            mismatches++;
          end
          void'(owed_q.pop_front());
        end
        out_wait = no_gaps ? 0 : $urandom_range(0, 7);
      end
      // stall for the drawn number of cycles, then stay ready
      if (out_wait > 0) begin
        rsp_ch.ready <= 1'b0;
        out_wait--;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // hang detection: cycles in which neither side moves an item
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < HANG_LIMIT) @(posedge clk);
    $display("FAIL modular_ring_alu_top");
    $finish;
  end

  initial begin
    logic [CFG_W-1:0] phase_mod[NUM_PHASES];
    // fixed settings first: extremes, small primes and composites, plus
    // out-of-range writes that must be ignored (0, 1, 17, all ones)
    phase_mod = '{5'd16, 5'd2, 5'd7, 5'd31, 5'd3, 5'd0, 5'd16, 5'd11,
                  5'd1, 5'd9, 5'd17, 5'd4, 5'd2, 5'd13, 5'd6, 5'd15};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.cmd = CMD_ADD;
    req_ch.operand_a = '0;
    req_ch.operand_b = '0;
    rsp_ch.ready = 1'b0;
    ring_mod = MODULUS_RESET;
    mismatches = 0;
    no_gaps = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed part at the reset modulus: operand extremes for every command
    for (int c = 0; c < 8; c++) begin
      push_op(cmd_t'(c), 15, 15);
      push_op(cmd_t'(c), 0, 0);
    end
    // divide by a value that reduces to zero, and a plain division
    push_op(CMD_DIV, 3, 5);
    push_op(CMD_DIV, 4, 2);
    // inverse of a value that reduces to zero, and of one that has an inverse
    push_op(CMD_INV, 10, 0);
    push_op(CMD_INV, 2, 9);
    // wrap-around cases
    push_op(CMD_INC, 4, 0);
    push_op(CMD_DEC, 0, 7);
    push_op(CMD_SUB, 1, 4);

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      write_modulus(phase_mod[p]);
      // after a rejected write, also try a random value (often out of range)
      if (phase_mod[p] < 2 || phase_mod[p] > MAX_MODULUS_DEF)
        write_modulus(CFG_W'($urandom_range(0, 31)));
      @(negedge clk);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        push_op(cmd_t'($urandom_range(0, 7)), $urandom_range(0, 15), $urandom_range(0, 15));
      end
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && owed_q.size() == 0) begin
      $display("PASS modular_ring_alu_top");
    end else begin
      $display("FAIL modular_ring_alu_top");
    end
    $finish;
  end

endmodule
